>>> rtl/core/jhtg_pkg.sv
// Shared types and constants of the JPEG header tile geometry block.
`default_nettype none
package jhtg_pkg;

  localparam int unsigned PROBE_BYTES = 65536;
  localparam int unsigned BYTES_W     = $clog2(PROBE_BYTES + 1);

  localparam logic [7:0] MK_FF  = 8'hFF;
  localparam logic [7:0] MK_SOI = 8'hD8;
  localparam logic [7:0] MK_SOS = 8'hDA;
  localparam logic [7:0] MK_DRI = 8'hDD;
  localparam logic [7:0] MK_RST0 = 8'hD0;
  localparam logic [7:0] MK_RST7 = 8'hD7;
  localparam logic [7:0] MK_TEM = 8'h01;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SOI    = 3'd1;
  localparam logic [2:0] ST_MALFORMED = 3'd2;
  localparam logic [2:0] ST_MISSING   = 3'd3;
  localparam logic [2:0] ST_MISMATCH  = 3'd4;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd5;

  // Parse summary of one stream, handed from the parser to the geometry unit.
  typedef struct packed {
    logic        ge4;
    logic        bad_soi;
    logic        malformed;
    logic        dri_seen;
    logic        sof_seen;
    logic [15:0] restart;
    logic [3:0]  max_h;
    logic [3:0]  max_v;
  } rec_t;

  typedef struct packed {
    logic        start;
    logic [32:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [32:0] quo;
    logic [31:0] rem;
  } div_rsp_t;

  function automatic logic is_frame_marker(input logic [7:0] m);
    return (m >= 8'hC0 && m <= 8'hC3) || (m >= 8'hC5 && m <= 8'hC7) ||
           (m >= 8'hC9 && m <= 8'hCB) || (m >= 8'hCD && m <= 8'hCF);
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/jhtg_front.sv
// Byte-serial marker parser: walks segments and emits one summary per stream.
`default_nettype none
module jhtg_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_last_byte,
  input  wire logic          q_full,
  output logic               q_push,
  output jhtg_pkg::rec_t     q_data
);

  typedef enum logic [9:0] {
    PH_SOI0      = 10'b0000000001,
    PH_SOI1      = 10'b0000000010,
    PH_SCAN      = 10'b0000000100,
    PH_FILL      = 10'b0000001000,
    PH_LENHI     = 10'b0000010000,
    PH_LENLO     = 10'b0000100000,
    PH_PAYLOAD   = 10'b0001000000,
    PH_SOS       = 10'b0010000000,
    PH_BADSOI    = 10'b0100000000,
    PH_MALFORMED = 10'b1000000000
  } phase_t;

  phase_t                         phase_r, phase_nxt;
  logic [jhtg_pkg::BYTES_W-1:0]   bytes_r, bytes_nxt;
  logic [15:0] seg_r, seg_nxt, pidx_r, pidx_nxt;
  logic [7:0]  marker_r, marker_nxt, lenhi_r, lenhi_nxt, cc_r, cc_nxt;
  logic        dri_r, dri_nxt, sof_r, sof_nxt;
  logic [15:0] rst_r, rst_nxt, prst_r, prst_nxt;
  logic [3:0]  mh_r, mh_nxt, mv_r, mv_nxt, ph_r, ph_nxt, pv_r, pv_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic [8:0]  k_r, k_nxt;

  logic        accept, take, fin, close_en;
  logic [15:0] close_len, len;
  logic [3:0]  fh, fv;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign fin      = (phase_r == PH_SOS) || (phase_r == PH_BADSOI) ||
                    (phase_r == PH_MALFORMED);
  assign take     = !fin && (bytes_r < jhtg_pkg::BYTES_W'(jhtg_pkg::PROBE_BYTES));
  assign len      = {lenhi_r, in_data_byte};
  assign fh       = (in_data_byte[7:4] == 4'd0) ? 4'd1 : in_data_byte[7:4];
  assign fv       = (in_data_byte[3:0] == 4'd0) ? 4'd1 : in_data_byte[3:0];

  always_comb begin
    phase_nxt = phase_r; bytes_nxt = bytes_r; seg_nxt = seg_r; pidx_nxt = pidx_r;
    marker_nxt = marker_r; lenhi_nxt = lenhi_r; cc_nxt = cc_r; dri_nxt = dri_r;
    sof_nxt = sof_r; rst_nxt = rst_r; prst_nxt = prst_r; mh_nxt = mh_r;
    mv_nxt = mv_r; ph_nxt = ph_r; pv_nxt = pv_r; sub_nxt = sub_r; k_nxt = k_r;
    close_en = 1'b0;
    close_len = 16'd0;
    if (accept && take) begin
      bytes_nxt = bytes_r + 1'b1;
      case (phase_r)
        PH_SOI0: phase_nxt = (in_data_byte == jhtg_pkg::MK_FF) ? PH_SOI1 : PH_BADSOI;
        PH_SOI1: phase_nxt = (in_data_byte == jhtg_pkg::MK_SOI) ? PH_SCAN : PH_BADSOI;
        PH_SCAN: if (in_data_byte == jhtg_pkg::MK_FF) phase_nxt = PH_FILL;
        PH_FILL: begin
          if (in_data_byte == jhtg_pkg::MK_FF) begin
            phase_nxt = PH_FILL;
          end else if (in_data_byte == jhtg_pkg::MK_SOS) begin
            phase_nxt = PH_SOS;
          end else if (in_data_byte == jhtg_pkg::MK_SOI || in_data_byte == jhtg_pkg::MK_TEM ||
                       (in_data_byte >= jhtg_pkg::MK_RST0 &&
                        in_data_byte <= jhtg_pkg::MK_RST7)) begin
            phase_nxt = PH_SCAN;
          end else begin
            marker_nxt = in_data_byte;
            phase_nxt  = PH_LENHI;
          end
        end
        PH_LENHI: begin
          lenhi_nxt = in_data_byte;
          phase_nxt = PH_LENLO;
        end
        PH_LENLO: begin
          if (len < 16'd2) begin
            phase_nxt = PH_MALFORMED;
          end else begin
            seg_nxt = len - 16'd2; pidx_nxt = 16'd0; cc_nxt = 8'd0; prst_nxt = 16'd0;
            ph_nxt = 4'd1; pv_nxt = 4'd1; sub_nxt = 2'd0; k_nxt = 9'd0;
            if (len == 16'd2) close_en = 1'b1;
            else phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (marker_r == jhtg_pkg::MK_DRI) begin
            if (pidx_r == 16'd0) prst_nxt = {in_data_byte, 8'd0};
            else if (pidx_r == 16'd1) prst_nxt = {prst_r[15:8], in_data_byte};
          end else if (jhtg_pkg::is_frame_marker(marker_r)) begin
            if (pidx_r == 16'd5) begin
              cc_nxt = in_data_byte;
            end else if (pidx_r >= 16'd7) begin
              // component bytes repeat every three; factors sit in the first
              if (sub_r == 2'd0 && k_r < {1'b0, cc_r}) begin
                if (fh > ph_r) ph_nxt = fh;
                if (fv > pv_r) pv_nxt = fv;
              end
              if (sub_r == 2'd0 && !k_r[8]) k_nxt = k_r + 1'b1;
              sub_nxt = (sub_r == 2'd2) ? 2'd0 : sub_r + 1'b1;
            end
          end
          pidx_nxt = pidx_r + 1'b1;
          seg_nxt  = seg_r - 1'b1;
          if (seg_r == 16'd1) begin
            close_en  = 1'b1;
            close_len = pidx_r + 1'b1;
          end
        end
        default: phase_nxt = phase_r;
      endcase
      if (close_en) begin
        phase_nxt = PH_SCAN;
        if (marker_r == jhtg_pkg::MK_DRI) begin
          if (close_len < 16'd2) begin
            phase_nxt = PH_MALFORMED;
          end else begin
            rst_nxt = prst_nxt;
            dri_nxt = 1'b1;
          end
        end else if (jhtg_pkg::is_frame_marker(marker_r)) begin
          if (close_len < 16'd8 ||
              (16'({cc_nxt, 1'b0}) + 16'(cc_nxt) + 16'd6) > close_len) begin
            phase_nxt = PH_MALFORMED;
          end else begin
            mh_nxt = ph_nxt; mv_nxt = pv_nxt; sof_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    q_push           = accept && in_last_byte;
    q_data.ge4       = (bytes_nxt >= jhtg_pkg::BYTES_W'(4));
    q_data.bad_soi   = (phase_nxt == PH_BADSOI);
    q_data.malformed = (phase_nxt == PH_MALFORMED);
    q_data.dri_seen  = dri_nxt;
    q_data.sof_seen  = sof_nxt;
    q_data.restart   = rst_nxt;
    q_data.max_h     = mh_nxt;
    q_data.max_v     = mv_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || q_push) begin
      phase_r <= PH_SOI0; bytes_r <= '0; seg_r <= '0; pidx_r <= '0; marker_r <= '0;
      lenhi_r <= '0; cc_r <= '0; dri_r <= 1'b0; sof_r <= 1'b0; rst_r <= '0;
      prst_r <= '0; mh_r <= 4'd1; mv_r <= 4'd1; ph_r <= 4'd1; pv_r <= 4'd1;
      sub_r <= '0; k_r <= '0;
    end else begin
      phase_r <= phase_nxt; bytes_r <= bytes_nxt; seg_r <= seg_nxt; pidx_r <= pidx_nxt;
      marker_r <= marker_nxt; lenhi_r <= lenhi_nxt; cc_r <= cc_nxt; dri_r <= dri_nxt;
      sof_r <= sof_nxt; rst_r <= rst_nxt; prst_r <= prst_nxt; mh_r <= mh_nxt;
      mv_r <= mv_nxt; ph_r <= ph_nxt; pv_r <= pv_nxt; sub_r <= sub_nxt; k_r <= k_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/jhtg_fifo.sv
// Two-entry queue of parse summaries between parser and geometry unit.
`default_nettype none
module jhtg_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  jhtg_pkg::rec_t      push_data,
  input  wire logic           pop,
  output jhtg_pkg::rec_t      pop_data,
  output logic                full,
  output logic                empty
);

  jhtg_pkg::rec_t mem_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt; rp_r <= rp_nxt; cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule
`default_nettype wire

>>> rtl/core/jhtg_div.sv
// Restoring divider, 33-bit dividend by 32-bit divisor, one quotient bit per cycle.
`default_nettype none
module jhtg_div (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  jhtg_pkg::div_req_t   req,
  output jhtg_pkg::div_rsp_t   rsp
);

  logic [32:0] quo_r, quo_nxt, rem_r, rem_nxt, trial;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt, fits;

  assign trial = {rem_r[31:0], quo_r[32]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt = req.dividend; rem_nxt = '0; dvs_nxt = req.divisor;
      cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - {1'b0, dvs_r}) : trial;
      quo_nxt = {quo_r[31:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; cnt_r <= cnt_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r[31:0];

endmodule
`default_nettype wire

>>> rtl/core/jhtg_back.sv
// Geometry unit: judges a parse summary and derives MCU and tile geometry.
`default_nettype none
module jhtg_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [31:0]    pic_width,
  input  wire logic [31:0]    pic_height,
  input  wire logic           q_empty,
  input  jhtg_pkg::rec_t      q_data,
  output logic                q_pop,
  output jhtg_pkg::div_req_t  div_req,
  input  jhtg_pkg::div_rsp_t  div_rsp,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          out_status,
  output logic [15:0]         out_rst_interval,
  output logic [6:0]          out_mcu_width,
  output logic [6:0]          out_mcu_height,
  output logic [15:0]         out_tile_width,
  output logic [6:0]          out_tile_height,
  output logic [31:0]         out_tiles_across,
  output logic [31:0]         out_tiles_down
);

  typedef enum logic [5:0] {
    BS_IDLE = 6'b000001,
    BS_DIV1 = 6'b000010,
    BS_DIV2 = 6'b000100,
    BS_CHK  = 6'b001000,
    BS_DIV3 = 6'b010000,
    BS_DIV4 = 6'b100000
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic [15:0] r_r, r_nxt;
  logic [6:0]  mw_r, mw_nxt, mh_r, mh_nxt;
  logic [22:0] tw_r, tw_nxt;
  logic [31:0] across_r, across_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  st_r, st_nxt;
  logic [15:0] ri_r, ri_nxt, tw_o_r, tw_o_nxt;
  logic [6:0]  mw_o_r, mw_o_nxt, mh_o_r, mh_o_nxt;
  logic [31:0] ta_r, ta_nxt, td_r, td_nxt;
  logic        emit;
  logic [2:0]  emit_st;
  logic [2:0]  pre_st;
  logic [6:0]  q_mw, q_mh;

  assign q_mw = {q_data.max_h, 3'b000};
  assign q_mh = {q_data.max_v, 3'b000};

  always_comb begin
    if (pic_width == 32'd0 || pic_height == 32'd0)    pre_st = jhtg_pkg::ST_ZERO_SIZE;
    else if (!q_data.ge4 || q_data.bad_soi)            pre_st = jhtg_pkg::ST_NO_SOI;
    else if (q_data.malformed)                        pre_st = jhtg_pkg::ST_MALFORMED;
    else if (!q_data.dri_seen || !q_data.sof_seen || q_data.restart == 16'd0)
                                                      pre_st = jhtg_pkg::ST_MISSING;
    else                                              pre_st = jhtg_pkg::ST_OK;
  end

  always_comb begin
    state_nxt = state_r; r_nxt = r_r; mw_nxt = mw_r; mh_nxt = mh_r; tw_nxt = tw_r;
    across_nxt = across_r;
    q_pop = 1'b0;
    div_req.start = 1'b0; div_req.dividend = '0; div_req.divisor = '0;
    emit = 1'b0; emit_st = jhtg_pkg::ST_OK;
    case (state_r)
      BS_IDLE: begin
        if (!q_empty && !ov_r) begin
          q_pop = 1'b1;
          r_nxt = q_data.restart; mw_nxt = q_mw; mh_nxt = q_mh;
          if (pre_st != jhtg_pkg::ST_OK) begin
            emit = 1'b1; emit_st = pre_st;
          end else begin
            // MCUs per row, rounded up
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, pic_width} + 33'(q_mw) - 33'd1;
            div_req.divisor  = 32'(q_mw);
            state_nxt        = BS_DIV1;
          end
        end
      end
      BS_DIV1: begin
        if (div_rsp.done) begin
          if (33'(r_r) > div_rsp.quo) begin
            emit = 1'b1; emit_st = jhtg_pkg::ST_MISMATCH; state_nxt = BS_IDLE;
          end else begin
            div_req.start = 1'b1; div_req.dividend = div_rsp.quo;
            div_req.divisor = 32'(r_r); state_nxt = BS_DIV2;
          end
        end
      end
      BS_DIV2: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != 32'd0) begin
            emit = 1'b1; emit_st = jhtg_pkg::ST_MISMATCH; state_nxt = BS_IDLE;
          end else begin
            tw_nxt = 23'(r_r) * 23'(mw_r); state_nxt = BS_CHK;
          end
        end
      end
      BS_CHK: begin
        if (tw_r[22:16] != 7'd0) begin
          emit = 1'b1; emit_st = jhtg_pkg::ST_MISMATCH; state_nxt = BS_IDLE;
        end else begin
          div_req.start = 1'b1; div_req.dividend = {1'b0, pic_width};
          div_req.divisor = 32'(tw_r); state_nxt = BS_DIV3;
        end
      end
      BS_DIV3: begin
        if (div_rsp.done) begin
          if (div_rsp.rem != 32'd0) begin
            emit = 1'b1; emit_st = jhtg_pkg::ST_MISMATCH; state_nxt = BS_IDLE;
          end else begin
            across_nxt       = div_rsp.quo[31:0];
            div_req.start    = 1'b1;
            div_req.dividend = {1'b0, pic_height} + 33'(mh_r) - 33'd1;
            div_req.divisor  = 32'(mh_r);
            state_nxt        = BS_DIV4;
          end
        end
      end
      BS_DIV4: begin
        if (div_rsp.done) begin
          emit = 1'b1; emit_st = jhtg_pkg::ST_OK; state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r; st_nxt = st_r; ri_nxt = ri_r; mw_o_nxt = mw_o_r; mh_o_nxt = mh_o_r;
    tw_o_nxt = tw_o_r; ta_nxt = ta_r; td_nxt = td_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (emit) begin
      ov_nxt = 1'b1;
      st_nxt = emit_st;
      if (emit_st == jhtg_pkg::ST_OK) begin
        ri_nxt = r_r; mw_o_nxt = mw_r; mh_o_nxt = mh_r; tw_o_nxt = tw_r[15:0];
        ta_nxt = across_r; td_nxt = div_rsp.quo[31:0];
      end else begin
        ri_nxt = '0; mw_o_nxt = '0; mh_o_nxt = '0; tw_o_nxt = '0; ta_nxt = '0; td_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt; mw_r <= mw_nxt; mh_r <= mh_nxt; tw_r <= tw_nxt; across_r <= across_nxt;
    st_r <= st_nxt; ri_r <= ri_nxt; mw_o_r <= mw_o_nxt; mh_o_r <= mh_o_nxt;
    tw_o_r <= tw_o_nxt; ta_r <= ta_nxt; td_r <= td_nxt;
  end

  assign out_valid            = ov_r;
  assign out_status           = st_r;
  assign out_rst_interval     = ri_r;
  assign out_mcu_width        = mw_o_r;
  assign out_mcu_height       = mh_o_r;
  assign out_tile_width       = tw_o_r;
  assign out_tile_height      = mh_o_r;
  assign out_tiles_across     = ta_r;
  assign out_tiles_down       = td_r;

endmodule
`default_nettype wire

>>> rtl/core/jpeg_header_tile_geometry.sv
// JPEG header probe: parses a byte stream and reports restart-tile geometry.
// Bytes enter at one per cycle while the queue has room; the parser handles
// each byte in the cycle it is accepted, and the byte flagged last_byte
// queues a summary of the stream for the geometry unit. That unit runs up to
// four divisions, one after another, on one shared restoring divider, and
// gives a result sooner when the stream fails a check. Two summaries can wait
// in the queue; beyond that the input stalls. Image width and height sit at APB
// byte addresses 0 and 4 and are read while the summary is judged. A result
// transaction carries zeros in every field but status when status is not ok.
`default_nettype none
module jpeg_header_tile_geometry (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [15:0]      out_rst_interval,
  output logic [6:0]       out_mcu_width,
  output logic [6:0]       out_mcu_height,
  output logic [15:0]      out_tile_width,
  output logic [6:0]       out_tile_height,
  output logic [31:0]      out_tiles_across,
  output logic [31:0]      out_tiles_down,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [31:0] width_r, width_nxt, height_r, height_nxt;
  logic        wr_en;

  jhtg_pkg::rec_t     push_data, pop_data;
  logic               q_push, q_pop, q_full, q_empty;
  jhtg_pkg::div_req_t div_req;
  jhtg_pkg::div_rsp_t div_rsp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = paddr[2] ? height_r : width_r;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      if (paddr[2]) height_nxt = pwdata;
      else          width_nxt  = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= '0; height_r <= '0;
    end else begin
      width_r <= width_nxt; height_r <= height_nxt;
    end
  end

  jhtg_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data_byte, .in_last_byte,
    .q_full, .q_push, .q_data(push_data)
  );

  jhtg_fifo u_fifo (
    .clk, .rst_n, .push(q_push), .push_data, .pop(q_pop), .pop_data,
    .full(q_full), .empty(q_empty)
  );

  jhtg_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  jhtg_back u_back (
    .clk, .rst_n, .pic_width(width_r), .pic_height(height_r),
    .q_empty, .q_data(pop_data), .q_pop, .div_req, .div_rsp,
    .out_valid, .out_ready, .out_status, .out_rst_interval, .out_mcu_width,
    .out_mcu_height, .out_tile_width, .out_tile_height, .out_tiles_across,
    .out_tiles_down
  );

endmodule
`default_nettype wire
